// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the rtl of the moment tensor block
// expects a clock named clk and a synchronous reset named rst in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off while reset is high
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked same-cycle implication, held off while reset is high
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  `ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`endif

// ===== hw/rtl/tomt_pkg.sv =====
// types and constants for the third-order moment tensor block
// no dependencies; used by third_order_moment_tensor
`timescale 1ns / 1ps

package tomt_pkg;

  // fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int INDEX_W  = 4;
  localparam int VALUE_W  = 64;
  localparam int CFG_W    = 5;
  localparam int PROD_W   = 48;
  localparam int PAIR_W   = 32;

  // register index of variable_count in the config map
  localparam logic REG_VARIABLE_COUNT = 1'b0;

  // input beat actions
  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } act_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PUT,
    S_SEEK_I,
    S_SEEK_J,
    S_RD_DATA,
    S_F_RD_I,
    S_F_GET_I,
    S_F_RD_J,
    S_F_MUL_IJ,
    S_F_MUL_K,
    S_F_ACC
  } st_t;

endpackage

// ===== hw/rtl/third_order_moment_tensor.sv =====
// third-order moment tensor accumulator: row buffer, cell store, shared multiplier
// depends on tomt_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
//   Input beats on s_* carry an action in s_tuser: push a sample, read a cell,
//   clear the store and the partial row. Every input beat gives exactly one output
//   beat on m_*: the cell value in m_tdata, the flags in m_tuser.
//   variable_count (n) sits at APB byte address 0; a write drops the partial row.
// Steps (from accept to result in the output register)
//   push that does not end a row, unused action code, bad read address: S_PUT
//   read of a good address: the offset walk (S_SEEK_I, S_SEEK_J), S_RD_DATA, S_PUT
//   push that ends a row: the fold over C = n(n+1)(n+2)/6 cells and
//   P = n(n+1)/2 pairs; each cell is worked on the one multiplier and the
//   store in turn (read, then add and write back)
//   clear: one store entry per cycle, all MAX_VARIABLES(MAX+1)(MAX+2)/6 entries
// The block takes one beat at a time; s_tready is high only between items.
// Reset: the store is swept to zero, one entry a cycle, with s_tready low;
//   APB writes are taken throughout the sweep.
// A stalled receiver holds the result in the output register; the next item is
//   still accepted and worked on, and waits only to hand over its own result.
module third_order_moment_tensor #(
  parameter int MAX_VARIABLES = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // sample[15:0], index_i[19:16], index_j[23:20], index_k[27:24]
  input  logic [1:0]  s_tuser,   // action[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // cell_value[63:0]
  output logic [2:0]  m_tuser,   // status[0], row_done[1], saturated[2]
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH  = MAX_VARIABLES * (MAX_VARIABLES + 1) * (MAX_VARIABLES + 2) / 6;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(MAX_VARIABLES + 1);
  localparam int RB_AW  = (MAX_VARIABLES > 1) ? $clog2(MAX_VARIABLES) : 1;
  localparam int CMP_W  = (CNT_W > tomt_pkg::CFG_W) ? CNT_W : tomt_pkg::CFG_W;
  localparam int TRI_M  = MAX_VARIABLES * (MAX_VARIABLES + 1) / 2;

  localparam logic [ADDR_W-1:0] M_A    = ADDR_W'(MAX_VARIABLES);
  localparam logic [ADDR_W-1:0] TRI_A  = ADDR_W'(TRI_M);
  localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  M_C    = CNT_W'(MAX_VARIABLES);

  tomt_pkg::st_t state, state_next;

  // control registers
  logic [tomt_pkg::CFG_W-1:0] vc;
  logic [CNT_W-1:0]  col;
  logic              sat_flag;
  logic [ADDR_W-1:0] clr_addr;
  logic              clr_resp;

  // sequencer datapath registers
  logic [CNT_W-1:0]  fi, fj, fk;
  logic [ADDR_W-1:0] pbase, tri_cur, rbase, caddr;
  logic signed [tomt_pkg::SAMPLE_W-1:0] ri;
  logic signed [tomt_pkg::PAIR_W-1:0]   ij;
  logic signed [tomt_pkg::PROD_W-1:0]   prod;
  logic [tomt_pkg::INDEX_W-1:0] req_i, req_j, req_k;
  logic [tomt_pkg::VALUE_W-1:0] res_value;
  logic              res_status, res_done;

  // memories
  logic signed [tomt_pkg::SAMPLE_W-1:0] rb [MAX_VARIABLES];
  logic signed [tomt_pkg::SAMPLE_W-1:0] rb_rdata;
  logic [tomt_pkg::VALUE_W-1:0] mem [DEPTH];
  logic [tomt_pkg::VALUE_W-1:0] mem_rdata;

  // combinational signals
  logic              accept, out_free, cfg_we;
  logic [CNT_W-1:0]  n_act, widx, col_inc, fi_inc, fj_inc, fk_inc;
  logic              row_end, addr_ok, fi_more, fj_more, fk_more, seek_i_more, seek_j_more;
  logic [ADDR_W-1:0] pbase_step, tri_step, rbase_step;
  logic              rb_we;
  logic [RB_AW-1:0]  rb_waddr, rb_raddr;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [tomt_pkg::VALUE_W-1:0] mem_wdata, sum, acc_value;
  logic              ovf;
  logic signed [tomt_pkg::PAIR_W-1:0] mul_a;
  logic signed [tomt_pkg::SAMPLE_W-1:0] mul_b;
  logic signed [tomt_pkg::PROD_W-1:0] mul_p;
  tomt_pkg::act_t    in_action;
  logic signed [tomt_pkg::SAMPLE_W-1:0] in_sample;
  logic [tomt_pkg::INDEX_W-1:0] in_i, in_j, in_k;

  // input beat unpacking
  assign in_action = tomt_pkg::act_t'(s_tuser);
  assign in_sample = s_tdata[15:0];
  assign in_i      = s_tdata[19:16];
  assign in_j      = s_tdata[23:20];
  assign in_k      = s_tdata[27:24];

  assign accept   = s_tvalid & s_tready;
  assign out_free = !m_tvalid || m_tready;

  // config port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr[2] == tomt_pkg::REG_VARIABLE_COUNT);
  assign prdata = (paddr[2] == tomt_pkg::REG_VARIABLE_COUNT) ? 32'(vc) : '0;

  // active variable count, clamped to 1..MAX_VARIABLES
  always_comb begin
    if (vc == '0) begin
      n_act = CNT_W'(1);
    end else if (CMP_W'(vc) > CMP_W'(MAX_VARIABLES)) begin
      n_act = M_C;
    end else begin
      n_act = CNT_W'(vc);
    end
  end

  // push bookkeeping and read address check
  assign widx    = (CMP_W'(col) >= CMP_W'(n_act)) ? '0 : col;
  assign col_inc = CNT_W'(widx + 1'b1);
  assign row_end = (col_inc == n_act);
  assign addr_ok = (in_i <= in_j) && (in_j <= in_k) && (CMP_W'(in_k) < CMP_W'(n_act));

  // loop counters of the fold
  assign fi_inc  = CNT_W'(fi + 1'b1);
  assign fj_inc  = CNT_W'(fj + 1'b1);
  assign fk_inc  = CNT_W'(fk + 1'b1);
  assign fi_more = (fi_inc != n_act);
  assign fj_more = (fj_inc != n_act);
  assign fk_more = (fk_inc != n_act);
  assign seek_i_more = CMP_W'(fi) < CMP_W'(req_i);
  assign seek_j_more = CMP_W'(fj) < CMP_W'(req_j);

  // triangular offset walk: plane base, plane size, row base
  assign pbase_step = pbase + tri_cur;
  assign tri_step   = tri_cur - (M_A - ADDR_W'(fi));
  assign rbase_step = rbase + (M_A - ADDR_W'(fj));

  // shared multiplier
  assign mul_b = rb_rdata;
  assign mul_p = mul_a * mul_b;

  // saturating accumulate
  assign sum = mem_rdata + 64'(prod);
  assign ovf = (mem_rdata[63] == prod[tomt_pkg::PROD_W-1]) && (sum[63] != mem_rdata[63]);
  always_comb begin
    if (!ovf) begin
      acc_value = sum;
    end else if (mem_rdata[63]) begin
      acc_value = {1'b1, {(tomt_pkg::VALUE_W-1){1'b0}}};
    end else begin
      acc_value = {1'b0, {(tomt_pkg::VALUE_W-1){1'b1}}};
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tomt_pkg::S_CLEAR: begin
        if (clr_addr == LAST_A) begin
          state_next = clr_resp ? tomt_pkg::S_PUT : tomt_pkg::S_IDLE;
        end
      end
      tomt_pkg::S_IDLE: begin
        if (accept) begin
          case (in_action)
            tomt_pkg::ACT_PUSH: begin
              state_next = row_end ? tomt_pkg::S_F_RD_I : tomt_pkg::S_PUT;
            end
            tomt_pkg::ACT_READ: begin
              state_next = addr_ok ? tomt_pkg::S_SEEK_I : tomt_pkg::S_PUT;
            end
            tomt_pkg::ACT_CLEAR: state_next = tomt_pkg::S_CLEAR;
            tomt_pkg::ACT_NONE:  state_next = tomt_pkg::S_PUT;
            default:             state_next = tomt_pkg::S_PUT;
          endcase
        end
      end
      tomt_pkg::S_PUT: begin
        if (out_free) begin
          state_next = tomt_pkg::S_IDLE;
        end
      end
      tomt_pkg::S_SEEK_I: begin
        if (!seek_i_more) begin
          state_next = tomt_pkg::S_SEEK_J;
        end
      end
      tomt_pkg::S_SEEK_J: begin
        if (!seek_j_more) begin
          state_next = tomt_pkg::S_RD_DATA;
        end
      end
      tomt_pkg::S_RD_DATA:  state_next = tomt_pkg::S_PUT;
      tomt_pkg::S_F_RD_I:   state_next = tomt_pkg::S_F_GET_I;
      tomt_pkg::S_F_GET_I:  state_next = tomt_pkg::S_F_MUL_IJ;
      tomt_pkg::S_F_RD_J:   state_next = tomt_pkg::S_F_MUL_IJ;
      tomt_pkg::S_F_MUL_IJ: state_next = tomt_pkg::S_F_MUL_K;
      tomt_pkg::S_F_MUL_K:  state_next = tomt_pkg::S_F_ACC;
      tomt_pkg::S_F_ACC: begin
        if (fk_more) begin
          state_next = tomt_pkg::S_F_MUL_K;
        end else if (fj_more) begin
          state_next = tomt_pkg::S_F_RD_J;
        end else if (fi_more) begin
          state_next = tomt_pkg::S_F_RD_I;
        end else begin
          state_next = tomt_pkg::S_PUT;
        end
      end
      default: state_next = tomt_pkg::S_IDLE;
    endcase
  end

  // control outputs: handshake, memory ports, multiplier operand
  always_comb begin
    s_tready  = 1'b0;
    rb_we     = 1'b0;
    rb_waddr  = RB_AW'(widx);
    rb_raddr  = RB_AW'(fj);
    mem_we    = 1'b0;
    mem_waddr = caddr;
    mem_wdata = acc_value;
    mem_re    = 1'b0;
    mem_raddr = rbase;
    mul_a     = ij;
    case (state)
      tomt_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      tomt_pkg::S_IDLE: begin
        s_tready = 1'b1;
        rb_we    = accept && (in_action == tomt_pkg::ACT_PUSH);
      end
      tomt_pkg::S_SEEK_J: begin
        if (!seek_j_more) begin
          mem_re    = 1'b1;
          mem_raddr = rbase + (ADDR_W'(req_k) - ADDR_W'(req_j));
        end
      end
      tomt_pkg::S_F_RD_I: begin
        rb_raddr = RB_AW'(fi);
      end
      tomt_pkg::S_F_MUL_IJ: begin
        mul_a  = 32'(ri);
        mem_re = 1'b1;
      end
      tomt_pkg::S_F_ACC: begin
        mem_we = 1'b1;
        if (fk_more) begin
          mem_re    = 1'b1;
          mem_raddr = caddr + 1'b1;
          rb_raddr  = RB_AW'(fk_inc);
        end
      end
      default: begin
      end
    endcase
  end

  // row buffer, registered read
  always_ff @(posedge clk) begin
    if (rb_we) begin
      rb[rb_waddr] <= in_sample;
    end
    rb_rdata <= rb[rb_raddr];
  end

  // cell store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tomt_pkg::S_CLEAR;
      vc       <= tomt_pkg::CFG_W'(16);
      col      <= '0;
      sat_flag <= 1'b0;
      clr_addr <= '0;
      clr_resp <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      // clear sweep
      if (state == tomt_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      // row position and clear start
      if (cfg_we) begin
        vc  <= pwdata[tomt_pkg::CFG_W-1:0];
        col <= '0;
      end else if (accept && (in_action == tomt_pkg::ACT_PUSH)) begin
        col <= row_end ? '0 : col_inc;
      end else if (accept && (in_action == tomt_pkg::ACT_CLEAR)) begin
        col <= '0;
      end
      if (accept && (in_action == tomt_pkg::ACT_CLEAR)) begin
        sat_flag <= 1'b0;
        clr_addr <= '0;
        clr_resp <= 1'b1;
      end else if ((state == tomt_pkg::S_F_ACC) && ovf) begin
        sat_flag <= 1'b1;
      end
      // output beat valid
      if ((state == tomt_pkg::S_PUT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    case (state)
      tomt_pkg::S_IDLE: begin
        if (accept) begin
          res_value  <= '0;
          res_status <= 1'b0;
          res_done   <= 1'b0;
          req_i      <= in_i;
          req_j      <= in_j;
          req_k      <= in_k;
          fi         <= '0;
          pbase      <= '0;
          tri_cur    <= TRI_A;
          if ((in_action == tomt_pkg::ACT_READ) && !addr_ok) begin
            res_status <= 1'b1;
          end
        end
      end
      tomt_pkg::S_SEEK_I: begin
        if (seek_i_more) begin
          pbase   <= pbase_step;
          tri_cur <= tri_step;
          fi      <= fi_inc;
        end else begin
          fj    <= fi;
          rbase <= pbase;
        end
      end
      tomt_pkg::S_SEEK_J: begin
        if (seek_j_more) begin
          rbase <= rbase_step;
          fj    <= fj_inc;
        end
      end
      tomt_pkg::S_RD_DATA: begin
        res_value <= mem_rdata;
      end
      tomt_pkg::S_F_RD_I: begin
        fj    <= fi;
        rbase <= pbase;
      end
      tomt_pkg::S_F_GET_I: begin
        ri <= rb_rdata;
      end
      tomt_pkg::S_F_MUL_IJ: begin
        ij    <= mul_p[tomt_pkg::PAIR_W-1:0];
        fk    <= fj;
        caddr <= rbase;
      end
      tomt_pkg::S_F_MUL_K: begin
        prod <= mul_p;
      end
      tomt_pkg::S_F_ACC: begin
        if (fk_more) begin
          fk    <= fk_inc;
          caddr <= caddr + 1'b1;
        end else if (fj_more) begin
          rbase <= rbase_step;
          fj    <= fj_inc;
        end else if (fi_more) begin
          pbase   <= pbase_step;
          tri_cur <= tri_step;
          fi      <= fi_inc;
        end else begin
          res_done <= 1'b1;
        end
      end
      tomt_pkg::S_PUT: begin
        if (out_free) begin
          m_tdata <= res_value;
          m_tuser <= {sat_flag, res_done, res_status};
        end
      end
      default: begin
      end
    endcase
  end

  // checks
  `ASSERT_CLK(a_col_below_n, (CMP_W'(col) < CMP_W'(n_act)), "row position not below n")
  `ASSERT_IMPL(a_acc_addr_range, (state == tomt_pkg::S_F_ACC), (caddr <= LAST_A),
               "fold cell address beyond store")
  `ASSERT_IMPL(a_flag_beat_zero, (m_tvalid && (m_tuser[1] || m_tuser[0])), (m_tdata == '0),
               "row end or bad read beat carries a value")
  `ASSERT_CLK(a_one_item, (s_tvalid && s_tready |=> !s_tready), "second item taken while busy")

endmodule
